/* hw/rtl/tcr_pkg.sv */
// ----------------------------------------------------------------------------
// tcr_pkg: shared types and constants for the triangle circumradius pipeline
// Holds the status codes, the per-item tag and the result width.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

    // Result width: Q36.4 radius
    localparam int RAD_BITS = 40;
    // Quotient bits needed ahead of the square root
    localparam int QUO_BITS = 2 * RAD_BITS;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_NOTRI = 2'd1,
        STS_DEGEN = 2'd2
    } t_status;

    // Control that travels with each item down the pipe
    typedef struct packed {
        logic    valid;
        t_status status;
        logic    sat;
    } t_tag;

endpackage

`default_nettype wire

/* hw/rtl/triangle_circumradius.sv */
// ----------------------------------------------------------------------------
// triangle_circumradius: circumradius of a triangle from its three sides
// Heron product P and N = 16abc, then radius = floor(sqrt(floor(N^2/P))).
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+---------------------------
//  command  | start, busy, i_side_a/b/c        | start high and busy low
//  result   | o_valid, o_radius, o_status      | o_valid high, one cycle
//
//  One item per cycle enters; each result passes through 5 product stages,
//  80 divider stages, 40 root stages and 1 output register.
//  busy stays low: the pipe never stalls, and the receiver cannot stall.
//  Synchronous active-low reset clears every stage valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumradius import tcr_pkg::*; #(
    parameter int SIDE_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [SIDE_WIDTH-1:0] i_side_a,
    input  wire logic [SIDE_WIDTH-1:0] i_side_b,
    input  wire logic [SIDE_WIDTH-1:0] i_side_c,
    output logic                       o_valid,
    output logic [RAD_BITS-1:0]        o_radius,
    output logic [1:0]                 o_status
);

    localparam int PW  = 4 * (SIDE_WIDTH + 2);
    localparam int RW  = 2 * (3 * SIDE_WIDTH + 4);
    localparam int LAT = 5 + QUO_BITS + RAD_BITS + 1;

    t_tag                fr_tag, dv_tag, sq_tag;
    logic [RW-1:0]       fr_n2;
    logic [PW-1:0]       fr_p;
    logic [QUO_BITS-1:0] dv_quo;
    logic [RAD_BITS-1:0] sq_root;

    logic                r_valid;
    logic [RAD_BITS-1:0] r_radius;
    t_status             r_status;

    assign busy = 1'b0;

    tcr_front #(.SW(SIDE_WIDTH), .PW(PW), .RW(RW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_a     (i_side_a),
        .i_b     (i_side_b),
        .i_c     (i_side_c),
        .o_tag   (fr_tag),
        .o_n2    (fr_n2),
        .o_p     (fr_p)
    );

    tcr_div #(.PW(PW), .RW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (fr_tag),
        .i_n2    (fr_n2),
        .i_p     (fr_p),
        .o_tag   (dv_tag),
        .o_quo   (dv_quo)
    );

    tcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (dv_tag),
        .i_d     (dv_quo),
        .o_tag   (sq_tag),
        .o_root  (sq_root)
    );

    // Hold the final result for its single strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= sq_tag.valid;
        end
    end

    // Zero on error, full scale on overflow
    always_ff @(posedge i_clk) begin
        r_status <= sq_tag.status;
        if (sq_tag.status != STS_OK) begin
            r_radius <= '0;
        end else if (sq_tag.sat) begin
            r_radius <= '1;
        end else begin
            r_radius <= sq_root;
        end
    end

    assign o_valid  = r_valid;
    assign o_radius = r_radius;
    assign o_status = r_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_OK |-> o_radius == '0)
        else $error("radius not zero on error status");

    a_sts_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == STS_OK || o_status == STS_NOTRI || o_status == STS_DEGEN)
        else $error("undefined status code");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching command");

endmodule

`default_nettype wire

/* hw/rtl/tcr_front.sv */
// ----------------------------------------------------------------------------
// tcr_front: Heron product and squared numerator
// Five stages: side factors and error flags, partial products, Heron
// product P and split square of N = 16abc, sum into N^2, overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_front import tcr_pkg::*; #(
    parameter int SW = 16,
    parameter int PW = 4 * (SW + 2),
    parameter int RW = 2 * (3 * SW + 4)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [SW-1:0] i_a,
    input  wire logic [SW-1:0] i_b,
    input  wire logic [SW-1:0] i_c,
    output t_tag               o_tag,
    output logic [RW-1:0]      o_n2,
    output logic [PW-1:0]      o_p
);

    localparam int FW  = SW + 2;
    localparam int SXW = SW + 3;
    localparam int NW  = 3 * SW + 4;
    localparam int LW  = NW / 2;
    localparam int HW  = NW - LW;
    localparam int CW  = (RW > PW + QUO_BITS) ? RW : PW + QUO_BITS;

    // Stage 1 combinational: signed side factors and status
    logic signed [SXW-1:0] ax, bx, cx, f0, f1, f2, f3;
    t_tag                  n1_tag;

    assign ax = signed'({3'b000, i_a});
    assign bx = signed'({3'b000, i_b});
    assign cx = signed'({3'b000, i_c});
    assign f0 = ax + bx + cx;
    assign f1 = bx + cx - ax;
    assign f2 = ax + cx - bx;
    assign f3 = ax + bx - cx;

    always_comb begin
        n1_tag.valid = i_valid;
        n1_tag.sat   = 1'b0;
        if (f0 == '0 || f1 == '0 || f2 == '0 || f3 == '0) begin
            n1_tag.status = STS_DEGEN;
        end else if (f1 < 0 || f2 < 0 || f3 < 0) begin
            n1_tag.status = STS_NOTRI;
        end else begin
            n1_tag.status = STS_OK;
        end
    end

    t_tag              r1_tag, r2_tag, r3_tag, r4_tag, r5_tag;
    logic [FW-1:0]     r1_f0, r1_f1, r1_f2, r1_f3;
    logic [2*SW-1:0]   r1_ab;
    logic [SW+3:0]     r1_c16;
    logic [2*FW-1:0]   r2_p01, r2_p23;
    logic [NW-1:0]     r2_n;
    logic [PW-1:0]     r3_p, r4_p, r5_p;
    logic [2*HW-1:0]   r3_hh;
    logic [NW-1:0]     r3_hl;
    logic [2*LW-1:0]   r3_ll;
    logic [RW-1:0]     r4_n2, r5_n2;
    logic [RW-1:0]     n4_n2;
    logic              n5_sat;

    // Advance the tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.valid <= 1'b0;
            r2_tag.valid <= 1'b0;
            r3_tag.valid <= 1'b0;
            r4_tag.valid <= 1'b0;
            r5_tag.valid <= 1'b0;
        end else begin
            r1_tag <= n1_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
            r5_tag <= '{valid: r4_tag.valid, status: r4_tag.status, sat: n5_sat};
        end
    end

    // Sum the partial products of N^2
    assign n4_n2 = (RW'(r3_hh) << (2 * LW)) + (RW'(r3_hl) << (LW + 1)) + RW'(r3_ll);
    // Flag a quotient of more than QUO_BITS bits
    assign n5_sat = CW'(r4_n2) >= (CW'(r4_p) << QUO_BITS);

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r1_f0  <= f0[FW-1:0];
        r1_f1  <= f1[FW-1:0];
        r1_f2  <= f2[FW-1:0];
        r1_f3  <= f3[FW-1:0];
        r1_ab  <= i_a * i_b;
        r1_c16 <= {i_c, 4'b0000};
        r2_p01 <= r1_f0 * r1_f1;
        r2_p23 <= r1_f2 * r1_f3;
        r2_n   <= NW'(r1_ab) * NW'(r1_c16);
        r3_p   <= r2_p01 * r2_p23;
        r3_hh  <= r2_n[NW-1:LW] * r2_n[NW-1:LW];
        r3_hl  <= r2_n[NW-1:LW] * r2_n[LW-1:0];
        r3_ll  <= r2_n[LW-1:0] * r2_n[LW-1:0];
        r4_p   <= r3_p;
        r4_n2  <= n4_n2;
        r5_p   <= r4_p;
        r5_n2  <= r4_n2;
    end

    assign o_tag = r5_tag;
    assign o_n2  = r5_n2;
    assign o_p   = r5_p;

endmodule

`default_nettype wire

/* hw/rtl/tcr_div.sv */
// ----------------------------------------------------------------------------
// tcr_div: pipelined restoring divider
// One quotient bit per stage: QUO_BITS stages give floor(N^2 / P) when it is below 2^80.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_div import tcr_pkg::*; #(
    parameter int PW = 72,
    parameter int RW = 104
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_tag          i_tag,
    input  wire logic [RW-1:0] i_n2,
    input  wire logic [PW-1:0] i_p,
    output t_tag               o_tag,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int CW = (RW > PW + QUO_BITS) ? RW : PW + QUO_BITS;

    t_tag                r_tag [QUO_BITS];
    logic [RW-1:0]       r_rem [QUO_BITS];
    logic [PW-1:0]       r_p   [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS];

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
        localparam int K = QUO_BITS - 1 - g;
        t_tag                s_tag;
        logic [RW-1:0]       s_rem;
        logic [PW-1:0]       s_p;
        logic [QUO_BITS-1:0] s_quo;
        logic [CW-1:0]       trial;
        logic                ge;

        if (g == 0) begin : g_first
            assign s_tag = i_tag;
            assign s_rem = i_n2;
            assign s_p   = i_p;
            assign s_quo = '0;
        end else begin : g_next
            assign s_tag = r_tag[g-1];
            assign s_rem = r_rem[g-1];
            assign s_p   = r_p[g-1];
            assign s_quo = r_quo[g-1];
        end

        // Try to subtract P shifted to this bit
        assign trial = CW'(s_p) << K;
        assign ge    = CW'(s_rem) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g].valid <= 1'b0;
            end else begin
                r_tag[g] <= s_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            r_p[g]   <= s_p;
            r_rem[g] <= ge ? s_rem - trial[RW-1:0] : s_rem;
            r_quo[g] <= {s_quo[QUO_BITS-2:0], ge};
        end
    end

    assign o_tag = r_tag[QUO_BITS-1];
    assign o_quo = r_quo[QUO_BITS-1];

endmodule

`default_nettype wire

/* hw/rtl/tcr_sqrt.sv */
// ----------------------------------------------------------------------------
// tcr_sqrt: pipelined integer square root
// Two radicand bits per stage; RAD_BITS stages give floor(sqrt(D)).
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_sqrt import tcr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_tag                i_tag,
    input  wire logic [QUO_BITS-1:0] i_d,
    output t_tag                     o_tag,
    output logic [RAD_BITS-1:0]      o_root
);

    localparam int MW = RAD_BITS + 3;

    t_tag                r_tag  [RAD_BITS];
    logic [QUO_BITS-1:0] r_d    [RAD_BITS];
    logic [MW-1:0]       r_rem  [RAD_BITS];
    logic [RAD_BITS-1:0] r_root [RAD_BITS];

    for (genvar g = 0; g < RAD_BITS; g++) begin : g_stage
        t_tag                s_tag;
        logic [QUO_BITS-1:0] s_d;
        logic [MW-1:0]       s_rem;
        logic [RAD_BITS-1:0] s_root;
        logic [MW-1:0]       rem2, trial;
        logic                ge;

        if (g == 0) begin : g_first
            assign s_tag  = i_tag;
            assign s_d    = i_d;
            assign s_rem  = '0;
            assign s_root = '0;
        end else begin : g_next
            assign s_tag  = r_tag[g-1];
            assign s_d    = r_d[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_root = r_root[g-1];
        end

        // Bring down two bits and try the next root bit
        assign rem2  = {s_rem[MW-3:0], s_d[QUO_BITS-1:QUO_BITS-2]};
        assign trial = {1'b0, s_root, 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g].valid <= 1'b0;
            end else begin
                r_tag[g] <= s_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[g]    <= {s_d[QUO_BITS-3:0], 2'b00};
            r_rem[g]  <= ge ? rem2 - trial : rem2;
            r_root[g] <= {s_root[RAD_BITS-2:0], ge};
        end
    end

    assign o_tag  = r_tag[RAD_BITS-1];
    assign o_root = r_root[RAD_BITS-1];

endmodule

`default_nettype wire
